@@ design/gsp_pkg.sv @@
// Package for the growing slot pool: default sizes, command codes and
// controller state encoding. No dependencies.
`default_nettype none

package gsp_pkg;

    localparam int SLOTS_DEF      = 64;
    localparam int VALUE_BITS_DEF = 32;
    localparam int CMD_BITS       = 2;
    localparam int VALUE_PORT_W   = 32;
    localparam int COUNT_PORT_W   = 7;

    typedef enum logic [CMD_BITS-1:0] {
        CMD_INSERT = 2'd0,
        CMD_REMOVE = 2'd1,
        CMD_MATCH  = 2'd2,
        CMD_NOP    = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_SCAN = 2'b10
    } state_t;

endpackage

`default_nettype wire

@@ design/gsp_mem.sv @@
// Slot store of the growing slot pool: one write port, one read port with
// registered read data. Depends on nothing.
`default_nettype none

module gsp_mem #(
    parameter int DEPTH = 64,
    parameter int WIDTH = 32
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

@@ design/growing_slot_pool_unit.sv @@
// Growing slot pool top level: command sequencer around the slot store.
// Depends on gsp_pkg and gsp_mem.
//
// Usage:
//   Raise start with command and value; the beat is taken when busy is low.
//   Insert fills the first empty allocated slot or appends a new one,
//   remove empties the first occupied slot, remove-match clears every
//   allocated slot equal to value. Each command gives one result, shown for
//   a single cycle while done is high; the receiver cannot stall it.
// Scan:
//   The sequencer walks the allocated slots in order, one memory read per
//   cycle, with registered read data. Insert and remove stop at the first
//   hit; without one they walk every allocated slot. Remove-match walks
//   every allocated slot. The unused command code answers without a scan.
//   A new command is taken in the cycle done is high.
// Reset:
//   One empty slot allocated and none occupied. No clearing pass: slots above
//   the allocated count are written before they are read, and slot zero reads
//   as empty until first written.
`default_nettype none

module growing_slot_pool_unit
    import gsp_pkg::*;
#(
    parameter int SLOTS      = SLOTS_DEF,
    parameter int VALUE_BITS = VALUE_BITS_DEF
) (
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic                    start,
    output logic                         busy,
    input  wire logic [CMD_BITS-1:0]     command,
    input  wire logic [VALUE_PORT_W-1:0] value,
    output logic                         done,
    output logic                         status,
    output logic [VALUE_PORT_W-1:0]      removed_value,
    output logic [COUNT_PORT_W-1:0]      match_count,
    output logic [COUNT_PORT_W-1:0]      occupied_count,
    output logic [COUNT_PORT_W-1:0]      allocated_count
);

    localparam int IDX_W = $clog2(SLOTS);
    localparam int CNT_W = $clog2(SLOTS + 1);

    state_t                state_reg, state_next;
    cmd_t                  cmd_reg, cmd_next;
    logic [VALUE_BITS-1:0] val_reg, val_next;
    logic [CNT_W-1:0]      rd_idx_reg, rd_idx_next;
    logic                  dv_reg, dv_next;
    logic [IDX_W-1:0]      d_idx_reg, d_idx_next;
    logic [CNT_W-1:0]      alloc_reg, alloc_next;
    logic [CNT_W-1:0]      occ_reg, occ_next;
    logic [CNT_W-1:0]      matches_reg, matches_next;
    logic                  slot0_wr_reg, slot0_wr_next;
    logic                  done_reg, done_next;
    logic                  status_reg, status_next;
    logic [VALUE_BITS-1:0] removed_reg, removed_next;

    logic                  mem_we;
    logic [IDX_W-1:0]      mem_waddr;
    logic [VALUE_BITS-1:0] mem_wdata;
    logic                  mem_re;
    logic [VALUE_BITS-1:0] mem_rdata;
    logic                  rd_en;
    logic [VALUE_BITS-1:0] slot_data;
    logic                  val_nz;

    gsp_mem #(
        .DEPTH (SLOTS),
        .WIDTH (VALUE_BITS)
    ) u_mem (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (rd_idx_reg[IDX_W-1:0]),
        .rdata (mem_rdata)
    );

    assign rd_en     = (state_reg == S_SCAN) && (rd_idx_reg < alloc_reg);
    assign slot_data = ((d_idx_reg == '0) && !slot0_wr_reg) ? '0 : mem_rdata;
    assign val_nz    = (val_reg != '0);

    always_comb
    begin
        state_next    = state_reg;
        cmd_next      = cmd_reg;
        val_next      = val_reg;
        rd_idx_next   = rd_idx_reg;
        dv_next       = dv_reg;
        d_idx_next    = d_idx_reg;
        alloc_next    = alloc_reg;
        occ_next      = occ_reg;
        matches_next  = matches_reg;
        slot0_wr_next = slot0_wr_reg;
        done_next     = 1'b0;
        status_next   = status_reg;
        removed_next  = removed_reg;
        mem_we        = 1'b0;
        mem_waddr     = d_idx_reg;
        mem_wdata     = '0;
        mem_re        = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    cmd_next     = cmd_t'(command);
                    val_next     = VALUE_BITS'(value);
                    rd_idx_next  = '0;
                    dv_next      = 1'b0;
                    matches_next = '0;
                    status_next  = 1'b0;
                    removed_next = '0;
                    if (cmd_t'(command) == CMD_NOP)
                    begin
                        done_next = 1'b1;
                    end
                    else
                    begin
                        state_next = S_SCAN;
                    end
                end
            end
            S_SCAN:
            begin
                mem_re  = rd_en;
                dv_next = rd_en;
                if (rd_en)
                begin
                    rd_idx_next = rd_idx_reg + CNT_W'(1);
                    d_idx_next  = rd_idx_reg[IDX_W-1:0];
                end
                if (dv_reg)
                begin
                    unique case (cmd_reg)
                        CMD_INSERT:
                        begin
                            if (slot_data == '0)
                            begin
                                mem_we     = 1'b1;
                                mem_wdata  = val_reg;
                                occ_next   = occ_reg + CNT_W'(val_nz);
                                done_next  = 1'b1;
                                state_next = S_IDLE;
                            end
                        end
                        CMD_REMOVE:
                        begin
                            if (slot_data != '0)
                            begin
                                mem_we       = 1'b1;
                                removed_next = slot_data;
                                occ_next     = occ_reg - CNT_W'(1);
                                done_next    = 1'b1;
                                state_next   = S_IDLE;
                            end
                        end
                        CMD_MATCH:
                        begin
                            if (slot_data == val_reg)
                            begin
                                mem_we       = 1'b1;
                                matches_next = matches_reg + CNT_W'(1);
                                occ_next     = occ_reg - CNT_W'(val_nz);
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
                else if (!rd_en)
                begin
                    if (cmd_reg == CMD_INSERT)
                    begin
                        if (alloc_reg < CNT_W'(SLOTS))
                        begin
                            mem_we     = 1'b1;
                            mem_waddr  = alloc_reg[IDX_W-1:0];
                            mem_wdata  = val_reg;
                            alloc_next = alloc_reg + CNT_W'(1);
                            occ_next   = occ_reg + CNT_W'(val_nz);
                        end
                        else
                        begin
                            status_next = 1'b1;
                        end
                    end
                    done_next  = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (mem_we && (mem_waddr == '0))
        begin
            slot0_wr_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            dv_reg       <= 1'b0;
            alloc_reg    <= CNT_W'(1);
            occ_reg      <= '0;
            slot0_wr_reg <= 1'b0;
            done_reg     <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            dv_reg       <= dv_next;
            alloc_reg    <= alloc_next;
            occ_reg      <= occ_next;
            slot0_wr_reg <= slot0_wr_next;
            done_reg     <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg     <= cmd_next;
        val_reg     <= val_next;
        rd_idx_reg  <= rd_idx_next;
        d_idx_reg   <= d_idx_next;
        matches_reg <= matches_next;
        status_reg  <= status_next;
        removed_reg <= removed_next;
    end

    assign busy            = (state_reg != S_IDLE);
    assign done            = done_reg;
    assign status          = status_reg;
    assign removed_value   = VALUE_PORT_W'(removed_reg);
    assign match_count     = COUNT_PORT_W'(matches_reg);
    assign occupied_count  = COUNT_PORT_W'(occ_reg);
    assign allocated_count = COUNT_PORT_W'(alloc_reg);

`ifndef NO_ASSERTIONS
    a_occ_bound: assert property (@(posedge clk) disable iff (!rst_n)
        occ_reg <= alloc_reg)
        else $error("occupied count exceeds allocated count");

    a_alloc_range: assert property (@(posedge clk) disable iff (!rst_n)
        (alloc_reg >= CNT_W'(1)) && (alloc_reg <= CNT_W'(SLOTS)))
        else $error("allocated count out of range");

    a_write_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
        mem_we |-> (state_reg == S_SCAN))
        else $error("slot write outside a scan");

    a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && (command != CMD_NOP)) |=> (busy && !done))
        else $error("accepted command did not enter the scan");
`endif

endmodule

`default_nettype wire
